// File: rtl/a2ab_pkg.sv
`default_nettype none
package a2ab_pkg;

	// parse position inside the configuration record
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_COUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_TAIL
	} phase_t;

	// summary status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_NO_COUNT = 3'd2,
		ST_NO_LEN   = 3'd3,
		ST_NO_DATA  = 3'd4
	} status_t;

	localparam logic [2:0] LEN_SIZE_RESET = 3'd4;
	localparam logic [2:0] HEADER_LEN_IDX = 3'd4;
	localparam logic [2:0] MIN_RECORD_LEN = 3'd7;
	localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
	localparam logic [7:0] PPS_COUNT_MASK = 8'hff;
	localparam logic [1:0] LEN_SIZE_MASK  = 2'h3;
	localparam logic [7:0] START_ZERO     = 8'h00;
	localparam logic [7:0] START_ONE      = 8'h01;
	localparam logic [2:0] START_LEN      = 3'd4;

	// one classified input beat, as handed from parser to emitter
	typedef struct packed {
		logic       has_start;
		logic       has_data;
		logic       has_sum;
		logic [7:0] data;
		status_t    status;
		logic [2:0] lsize;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/avcc_to_annexb_converter.sv
`default_nettype none
// channel   dir  width            contents
// s_*       in   tdata 8          in_byte; tlast = record_end
// m_*       out  tdata 16, user 1 out_byte, status, length_size; tuser = kind;
//                                 tlast = last_of_run
//
// a record byte is taken whenever the command queue has room; the emitter
// sends one beat a cycle while m_tready is high, so a data byte yields one
// beat and the low length byte of a parameter set yields four (start code),
// plus one for the summary on the final byte
// arst_n clears parse state, queue and output valid; length size resets to 4
// output stalls back up through the queue to s_tready only once it is full
module avcc_to_annexb_converter
	import a2ab_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] status, [13:11] length_size
	output logic             m_tuser,   // [0] kind
	output logic             m_tlast
);

	cmd_t cmd;
	cmd_t head;
	logic push;
	logic full;
	logic pop;
	logic head_valid;
	logic accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	a2ab_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (s_tdata),
		.record_end (s_tlast),
		.cmd        (cmd),
		.push       (push)
	);

	a2ab_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (cmd),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid)
	);

	a2ab_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

// File: rtl/a2ab_parser.sv
`default_nettype none
module a2ab_parser
	import a2ab_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       record_end,
	output cmd_t            cmd,
	output logic            push
);

	phase_t      phase_q, phase_nx;
	logic [2:0]  hidx_q, hidx_nx;
	logic [7:0]  sets_q, sets_nx;
	logic [15:0] dleft_q, dleft_nx;
	logic [7:0]  lenh_q, lenh_nx;
	logic        in_pps_q, in_pps_nx;
	logic [2:0]  seen_q, seen_nx;
	logic [2:0]  lsize_q, lsize_nx;
	logic [7:0]  count_val;
	logic [7:0]  sets_m1;
	logic        set_end;

	// parse step for one byte
	always_comb begin
		phase_nx  = phase_q;
		hidx_nx   = hidx_q;
		sets_nx   = sets_q;
		dleft_nx  = dleft_q;
		lenh_nx   = lenh_q;
		in_pps_nx = in_pps_q;
		lsize_nx  = lsize_q;
		set_end   = 1'b0;
		cmd       = '0;
		count_val = in_byte & (in_pps_q ? PPS_COUNT_MASK : SPS_COUNT_MASK);
		sets_m1   = sets_q - 8'd1;
		seen_nx   = (seen_q < MIN_RECORD_LEN) ? seen_q + 3'd1 : seen_q;

		case (phase_q)
			PH_HEADER: begin
				if (hidx_q == HEADER_LEN_IDX) begin
					lsize_nx = {1'b0, in_byte[1:0] & LEN_SIZE_MASK} + 3'd1;
					phase_nx = PH_COUNT;
					hidx_nx  = 3'd0;
				end else begin
					hidx_nx = hidx_q + 3'd1;
				end
			end
			PH_COUNT: begin
				sets_nx = count_val;
				if (count_val != 8'd0) begin
					phase_nx = PH_LEN_HI;
				end else if (!in_pps_q) begin
					in_pps_nx = 1'b1;
				end else begin
					phase_nx = PH_TAIL;
				end
			end
			PH_LEN_HI: begin
				lenh_nx  = in_byte;
				phase_nx = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				dleft_nx      = {lenh_q, in_byte};
				cmd.has_start = 1'b1;
				if (dleft_nx != 16'd0) begin
					phase_nx = PH_DATA;
				end else begin
					set_end = 1'b1;
				end
			end
			PH_DATA: begin
				cmd.has_data = 1'b1;
				dleft_nx     = dleft_q - 16'd1;
				set_end      = (dleft_nx == 16'd0);
			end
			default: begin
			end
		endcase

		// end of one parameter set
		if (set_end) begin
			sets_nx = sets_m1;
			if (sets_m1 != 8'd0) begin
				phase_nx = PH_LEN_HI;
			end else if (!in_pps_q) begin
				in_pps_nx = 1'b1;
				phase_nx  = PH_COUNT;
			end else begin
				phase_nx = PH_TAIL;
			end
		end

		// summary on the final byte
		cmd.data  = in_byte;
		cmd.lsize = lsize_nx;
		if (record_end) begin
			cmd.has_sum = 1'b1;
			if (seen_nx < MIN_RECORD_LEN) begin
				cmd.status = ST_SHORT;
			end else begin
				case (phase_nx)
					PH_HEADER, PH_COUNT: cmd.status = ST_NO_COUNT;
					PH_LEN_HI, PH_LEN_LO: cmd.status = ST_NO_LEN;
					PH_DATA: cmd.status = ST_NO_DATA;
					default: cmd.status = ST_OK;
				endcase
			end
		end
		push = accept && (cmd.has_start || cmd.has_data || cmd.has_sum);
	end

	// parse state, cleared at record end except the length size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hidx_q   <= 3'd0;
			sets_q   <= 8'd0;
			dleft_q  <= 16'd0;
			lenh_q   <= 8'd0;
			in_pps_q <= 1'b0;
			seen_q   <= 3'd0;
			lsize_q  <= LEN_SIZE_RESET;
		end else if (accept) begin
			lsize_q <= lsize_nx;
			if (record_end) begin
				phase_q  <= PH_HEADER;
				hidx_q   <= 3'd0;
				sets_q   <= 8'd0;
				dleft_q  <= 16'd0;
				lenh_q   <= 8'd0;
				in_pps_q <= 1'b0;
				seen_q   <= 3'd0;
			end else begin
				phase_q  <= phase_nx;
				hidx_q   <= hidx_nx;
				sets_q   <= sets_nx;
				dleft_q  <= dleft_nx;
				lenh_q   <= lenh_nx;
				in_pps_q <= in_pps_nx;
				seen_q   <= seen_nx;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/a2ab_queue.sv
`default_nettype none
module a2ab_queue
	import a2ab_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("fill count did not follow a write");

endmodule
`default_nettype wire

// File: rtl/a2ab_emitter.sv
`default_nettype none
module a2ab_emitter
	import a2ab_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head,
	input  wire logic        head_valid,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	logic [2:0] step_q;
	logic [2:0] n_stream;
	logic [2:0] total;
	logic       is_last;
	logic       load;
	logic       valid_q;
	logic [7:0] byte_q;
	status_t    status_q;
	logic [2:0] lsize_q;
	logic       kind_q;
	logic       last_q;
	logic [7:0] nx_byte;
	status_t    nx_status;
	logic       nx_kind;

	// pick the result for the current step of the head entry
	always_comb begin
		n_stream = head.has_start ? START_LEN : {2'b00, head.has_data};
		total    = n_stream + {2'b00, head.has_sum};
		is_last  = (step_q == total - 3'd1);
		load     = head_valid && (!valid_q || m_tready);
		pop      = load && is_last;
		if (step_q < n_stream) begin
			nx_kind   = 1'b0;
			nx_status = ST_OK;
			if (head.has_start) begin
				nx_byte = (step_q == START_LEN - 3'd1) ? START_ONE : START_ZERO;
			end else begin
				nx_byte = head.data;
			end
		end else begin
			nx_kind   = 1'b1;
			nx_status = head.status;
			nx_byte   = START_ZERO;
		end
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 3'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			step_q  <= is_last ? 3'd0 : step_q + 3'd1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nx_byte;
			status_q <= nx_status;
			lsize_q  <= head.lsize;
			kind_q   <= nx_kind;
			last_q   <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, lsize_q, status_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

// File: verif/avcc_to_annexb_converter_tb.sv
`default_nettype none
module avcc_to_annexb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import a2ab_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 80;
	localparam int DIRECTED_ROWS = 24;
	localparam int MAX_PRINTED = 50;

	// one output beat as the consumer sees it
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		status_t    st;
		logic [2:0] lsize;
	} out_beat_t;

	// one directed input beat; typed rows carry their summary by hand
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		status_t    st;
		logic [2:0] lsize;
	} dir_row_t;

	typedef struct packed {
		logic       typed;
		status_t    st;
		logic [2:0] lsize;
	} beat_tag_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	avcc_to_annexb_converter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	out_beat_t annexb_expected[$];
	beat_tag_t offered_tags[$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        hold_request = 1'b0;
	bit        hold_done = 1'b0;

	// parser copy for prediction
	phase_t     parse_phase = PH_HEADER;
	logic [2:0] hdr_idx = '0;
	logic [7:0] sets_remaining = '0;
	logic [15:0] data_remaining = '0;
	logic [7:0] len_hi_byte = '0;
	logic       pps_list = 1'b0;
	logic [2:0] seen_count = '0;
	logic [2:0] nal_size = LEN_SIZE_RESET;

	out_beat_t  step_beats [0:4];
	int         step_count;

	function automatic void add_beat(input logic kind, input logic [7:0] data,
			input status_t st);
		if (step_count < 5) begin
			step_beats[step_count] = '{kind: kind, data: data, last: 1'b0,
				st: st, lsize: nal_size};
			step_count++;
		end
	endfunction

	// one parameter set finished: next set, next list or tail
	function automatic void finish_set();
		sets_remaining = sets_remaining - 8'd1;
		if (sets_remaining != 8'd0)
			parse_phase = PH_LEN_HI;
		else if (!pps_list) begin
			pps_list = 1'b1;
			parse_phase = PH_COUNT;
		end else
			parse_phase = PH_TAIL;
	endfunction

	// results that one record byte causes, left in step_beats
	function automatic void annexb_step(input logic [7:0] b, input logic fin);
		status_t st;
		step_count = 0;
		if (seen_count < MIN_RECORD_LEN)
			seen_count = seen_count + 3'd1;
		case (parse_phase)
			PH_HEADER: begin
				if (hdr_idx == HEADER_LEN_IDX) begin
					nal_size = {1'b0, b[1:0] & LEN_SIZE_MASK} + 3'd1;
					parse_phase = PH_COUNT;
					hdr_idx = '0;
				end else
					hdr_idx = hdr_idx + 3'd1;
			end
			PH_COUNT: begin
				sets_remaining = b & (pps_list ? PPS_COUNT_MASK : SPS_COUNT_MASK);
				if (sets_remaining != 8'd0)
					parse_phase = PH_LEN_HI;
				else if (!pps_list)
					pps_list = 1'b1;
				else
					parse_phase = PH_TAIL;
			end
			PH_LEN_HI: begin
				len_hi_byte = b;
				parse_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				data_remaining = {len_hi_byte, b};
				add_beat(1'b0, START_ZERO, ST_OK);
				add_beat(1'b0, START_ZERO, ST_OK);
				add_beat(1'b0, START_ZERO, ST_OK);
				add_beat(1'b0, START_ONE, ST_OK);
				if (data_remaining != 16'd0)
					parse_phase = PH_DATA;
				else
					finish_set();
			end
			PH_DATA: begin
				add_beat(1'b0, b, ST_OK);
				data_remaining = data_remaining - 16'd1;
				if (data_remaining == 16'd0)
					finish_set();
			end
			default: ;
		endcase
		if (fin) begin
			if (seen_count < MIN_RECORD_LEN)
				st = ST_SHORT;
			else if (parse_phase == PH_HEADER || parse_phase == PH_COUNT)
				st = ST_NO_COUNT;
			else if (parse_phase == PH_LEN_HI || parse_phase == PH_LEN_LO)
				st = ST_NO_LEN;
			else if (parse_phase == PH_DATA)
				st = ST_NO_DATA;
			else
				st = ST_OK;
			add_beat(1'b1, 8'h00, st);
			parse_phase = PH_HEADER;
			hdr_idx = '0;
			sets_remaining = '0;
			data_remaining = '0;
			len_hi_byte = '0;
			pps_list = 1'b0;
			seen_count = '0;
		end
		if (step_count > 0)
			step_beats[step_count - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// alternating stretches of no idling and random idling
	function automatic int draw_wait(inout bit calm, inout int left);
		if (left == 0) begin
			calm = !calm;
			left = $urandom_range(5, 30);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// predict on accepted input, check accepted output
	always @(posedge clk) begin
		beat_tag_t tag;
		out_beat_t want;
		if (arst_n && s_tvalid && s_tready) begin
			tag = offered_tags.pop_front();
			annexb_step(s_tdata, s_tlast);
			if (tag.typed)
				annexb_expected.push_back('{kind: 1'b1, data: 8'h00, last: 1'b1,
					st: tag.st, lsize: tag.lsize});
			else
				for (int i = 0; i < step_count; i++)
					annexb_expected.push_back(step_beats[i]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (annexb_expected.size() == 0)
				report_mismatch("beat with nothing expected", m_tdata, 0);
			else begin
				want = annexb_expected.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", m_tuser, want.kind);
				if (m_tdata[7:0] !== want.data)
					report_mismatch("out_byte", m_tdata[7:0], want.data);
				if (m_tdata[10:8] !== want.st)
					report_mismatch("status", m_tdata[10:8], want.st);
				if (m_tdata[13:11] !== want.lsize)
					report_mismatch("length_size", m_tdata[13:11], want.lsize);
				if (m_tdata[15:14] !== 2'b00)
					report_mismatch("tdata padding", m_tdata[15:14], 0);
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", m_tlast, want.last);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sink side with random stalls and one long hold-off
	initial begin : sink
		bit calm;
		int left;
		int stall;
		calm = 1'b0;
		left = 0;
		wait (arst_n);
		forever begin
			stall = draw_wait(calm, left);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	bit src_calm = 1'b0;
	int src_left = 0;
	int items_sent = 0;

	// offer one record byte and wait until it is accepted
	task automatic send_byte(input logic [7:0] b, input logic fin, input beat_tag_t tag);
		int gap;
		gap = draw_wait(src_calm, src_left);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		offered_tags.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic void add_set(ref logic [7:0] rec[$]);
		int len;
		len = $urandom_range(0, 6);
		rec.push_back(8'(len >> 8));
		rec.push_back(8'(len));
		repeat (len) rec.push_back(8'($urandom));
	endfunction

	// one random record: mostly well formed, some broken, some noise
	task automatic send_record();
		logic [7:0] rec[$];
		int sel;
		int cut;
		int nsets;
		beat_tag_t plain;
		plain = '{typed: 1'b0, st: ST_OK, lsize: 3'd0};
		sel = $urandom_range(0, 7);
		if (sel == 0)
			repeat ($urandom_range(1, 12)) rec.push_back(8'($urandom));
		else begin
			repeat (5) rec.push_back(8'($urandom));
			nsets = $urandom_range(0, 2);
			rec.push_back({3'($urandom), 5'(nsets)});
			repeat (nsets) add_set(rec);
			nsets = $urandom_range(0, 2);
			rec.push_back(8'(nsets));
			repeat (nsets) add_set(rec);
			repeat ($urandom_range(0, 2)) rec.push_back(8'($urandom));
			// broken record: one byte corrupted, then possibly cut short
			if (sel <= 2) begin
				rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom);
				cut = $urandom_range(1, rec.size());
				while (rec.size() > cut) void'(rec.pop_back());
			end
		end
		for (int i = 0; i < rec.size(); i++)
			send_byte(rec[i], i == rec.size() - 1, plain);
	endtask

	dir_row_t directed_rows [DIRECTED_ROWS];

	initial begin
		// short record right after reset, then one cut off before the pps
		// count, then a full record with a zero-length set and a tail byte
		directed_rows = '{
			'{8'h01, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hff, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b1, 1'b1, ST_SHORT,    LEN_SIZE_RESET},
			'{8'h01, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h64, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h1f, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hff, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'he1, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b1, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hff, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hff, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hff, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hfc, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'he1, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h01, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'hab, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h01, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h00, 1'b0, 1'b0, ST_OK,       3'd0},
			'{8'h55, 1'b1, 1'b1, ST_OK,       3'd1}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(directed_rows[i].b, directed_rows[i].fin,
				'{typed: directed_rows[i].typed, st: directed_rows[i].st,
				lsize: directed_rows[i].lsize});

		// random records; the sink holds off once to back up the input
		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if (!hold_done && items_sent >= DIRECTED_ROWS + 30) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			send_record();
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		// drain, then allow for any stray beats
		while (annexb_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// File: avcc_to_annexb_converter.f
rtl/a2ab_pkg.sv
rtl/a2ab_parser.sv
rtl/a2ab_queue.sv
rtl/a2ab_emitter.sv
rtl/avcc_to_annexb_converter.sv
verif/avcc_to_annexb_converter_tb.sv
